@@ sv/bia_pkg.sv @@
package bia_pkg;

   // Fixed widths of the identifier, offset and count fields.
   localparam int ID_W       = 17;
   localparam int OFF_W      = 16;
   localparam int CNT_W      = 13;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_ID_OFFSET  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDS_IN_USE = 1'd1;

   // Request operations.
   typedef enum logic [1:0] {
      OP_ALLOC   = 2'd0,
      OP_RELEASE = 2'd1,
      OP_USED    = 2'd2,
      OP_VALID   = 2'd3
   } op_type;

   // Sequencer states, one-hot.
   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_LOOKUP = 2'b10
   } state_type;

endpackage

@@ sv/bitmap_id_allocator.sv @@
// Bitmap identifier allocator. A request is taken when start is high and busy
// is low; its single result appears on the rsp_ ports for exactly one cycle,
// marked by rsp_valid, and cannot be held off. Valid queries, releases and
// used queries on an identifier outside the managed range and allocates that
// find every managed line full answer in the cycle after they are taken;
// other allocates, releases and used queries go through the lookup state,
// bound by the registered mark memory read and the one priority encoder that
// first picks a non-full word from a summary vector and then its free bit.
// A new request can be taken in the cycle in which the previous result shows.
// The marks are clear after reset without a clearing pass, and configuration
// writes take effect at once and must only be issued while the block is idle.
module bitmap_id_allocator
   import bia_pkg::*;
#(
   parameter int MAX_IDS   = 4096,
   parameter int WORD_BITS = 64
)
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_op,
   input  logic [ID_W-1:0]              req_id,
   output logic                         rsp_valid,
   output logic [ID_W-1:0]              rsp_result_id,
   output logic                         rsp_success,
   output logic                         rsp_answer_flag,
   input  logic                         csr_write_en,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_write_data
);

   // Storage is organized in lines of a power-of-two number of marks.
   localparam int LINE_SH   = $clog2(WORD_BITS);
   localparam int LINE_W    = 1 << LINE_SH;
   localparam int NUM_WORDS = (MAX_IDS + LINE_W - 1) / LINE_W;
   localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int UNIT_W    = (NUM_WORDS > LINE_W) ? NUM_WORDS : LINE_W;
   localparam int UNIT_IW   = $clog2(UNIT_W);
   localparam int FOUND_W   = WADDR_W + LINE_SH;
   localparam int SZ_LOG    = $clog2(MAX_IDS + 1);
   localparam int SZ_W      = (SZ_LOG > CNT_W) ? SZ_LOG : CNT_W;
   localparam int CW        = ((SZ_W > ID_W) ? SZ_W : ID_W) + 1;
   localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(MAX_IDS);

   state_type                state_ff, state_in;
   op_type                   op_ff, op_in;
   logic [WADDR_W-1:0]       word_ff, word_in;
   logic [LINE_SH-1:0]       bit_ff, bit_in;
   logic [NUM_WORDS-1:0]     full_ff;
   logic [NUM_WORDS-1:0]     valid_ff;
   logic [OFF_W-1:0]         id_offset_ff;
   logic [CNT_W-1:0]         ids_in_use_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]          rsp_result_id_ff, rsp_result_id_in;
   logic                     rsp_success_ff, rsp_success_in;
   logic                     rsp_answer_flag_ff, rsp_answer_flag_in;

   logic                     accept;
   op_type                   req_op_t;
   logic [SZ_W-1:0]          ids_ext;
   logic [SZ_W-1:0]          size;
   logic [ID_W:0]            idx_diff;
   logic                     req_valid;
   logic [WADDR_W-1:0]       req_word;
   logic [LINE_SH-1:0]       req_bit;
   logic [ID_W-1:0]          off_ext;
   logic [NUM_WORDS-1:0]     search_en;
   logic [UNIT_W-1:0]        unit_vec;
   logic                     unit_found;
   logic [UNIT_IW-1:0]       unit_index;
   logic [LINE_W-1:0]        ram_rdata;
   logic [LINE_W-1:0]        word_data;
   logic [FOUND_W-1:0]       found_idx;
   logic                     ram_we;
   logic [LINE_W-1:0]        ram_wdata;
   logic                     ram_re;
   logic [WADDR_W-1:0]       ram_raddr;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign req_op_t = op_type'(req_op);

   // Managed count, limited to the capacity.
   assign ids_ext = SZ_W'(ids_in_use_ff);
   assign size    = (ids_ext > SZ_W'(MAX_IDS)) ? SZ_W'(MAX_IDS) : ids_ext;

   // Bitmap index of the requested identifier and its range check.
   assign off_ext   = {id_offset_ff[OFF_W-1], id_offset_ff};
   assign idx_diff  = {req_id[ID_W-1], req_id} - {off_ext[ID_W-1], off_ext};
   assign req_valid = !idx_diff[ID_W] && (CW'(idx_diff[ID_W-1:0]) < CW'(size));
   assign req_word  = WADDR_W'(idx_diff[ID_W-1:LINE_SH]);
   assign req_bit   = idx_diff[LINE_SH-1:0];

   // Lines that hold at least one managed index take part in the search.
   for (genvar w = 0; w < NUM_WORDS; w++) begin : g_search
      assign search_en[w] = (CW'(w * LINE_W) < CW'(size));
   end

   // A line that was never written reads as all marks clear.
   assign word_data = valid_ff[word_ff] ? ram_rdata : '0;
   assign found_idx = {word_ff, LINE_SH'(unit_index)};

   // The shared encoder first scans the summary of non-full lines, then the
   // free bits of the chosen line.
   assign unit_vec = (state_ff == ST_IDLE) ? UNIT_W'(~full_ff & search_en)
                                           : UNIT_W'(~word_data);

   bia_ffs #(
      .WIDTH (UNIT_W)
   ) u_ffs (
      .vec   (unit_vec),
      .found (unit_found),
      .index (unit_index)
   );

   bia_ram #(
      .DATA_W (LINE_W),
      .DEPTH  (NUM_WORDS)
   ) u_marks (
      .clock (clock),
      .we    (ram_we),
      .waddr (word_ff),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Sequencer and result formation.
   always_comb begin
      state_in           = state_ff;
      op_in              = op_ff;
      word_in            = word_ff;
      bit_in             = bit_ff;
      rsp_valid_in       = 1'b0;
      rsp_result_id_in   = '0;
      rsp_success_in     = 1'b0;
      rsp_answer_flag_in = 1'b0;
      ram_re             = 1'b0;
      ram_raddr          = req_word;
      ram_we             = 1'b0;
      ram_wdata          = word_data;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in   = req_op_t;
               word_in = req_word;
               bit_in  = req_bit;
               case (req_op_t)
                  OP_ALLOC: begin
                     if (unit_found) begin
                        word_in   = WADDR_W'(unit_index);
                        ram_raddr = WADDR_W'(unit_index);
                        ram_re    = 1'b1;
                        state_in  = ST_LOOKUP;
                     end else begin
                        rsp_valid_in     = 1'b1;
                        rsp_result_id_in = off_ext - ID_W'(1);
                     end
                  end
                  OP_RELEASE, OP_USED: begin
                     if (req_valid) begin
                        ram_re   = 1'b1;
                        state_in = ST_LOOKUP;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  OP_VALID: begin
                     rsp_valid_in       = 1'b1;
                     rsp_answer_flag_in = req_valid;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_LOOKUP: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
            case (op_ff)
               OP_ALLOC: begin
                  if (unit_found && (CW'(found_idx) < CW'(size))) begin
                     ram_we           = 1'b1;
                     ram_wdata        = word_data | (LINE_W'(1) << LINE_SH'(unit_index));
                     rsp_result_id_in = ID_W'(found_idx) + off_ext;
                     rsp_success_in   = 1'b1;
                  end else begin
                     rsp_result_id_in = off_ext - ID_W'(1);
                  end
               end
               OP_RELEASE: begin
                  ram_we         = 1'b1;
                  ram_wdata      = word_data & ~(LINE_W'(1) << bit_ff);
                  rsp_success_in = 1'b1;
               end
               OP_USED: begin
                  rsp_answer_flag_in = word_data[bit_ff];
               end
               default: begin
                  rsp_answer_flag_in = 1'b0;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state, summary of full lines and line valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         full_ff      <= '0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ram_we) begin
            full_ff[word_ff]  <= &ram_wdata;
            valid_ff[word_ff] <= 1'b1;
         end
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         id_offset_ff  <= '0;
         ids_in_use_ff <= CNT_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_ID_OFFSET:  id_offset_ff  <= csr_write_data[OFF_W-1:0];
            CSR_IDS_IN_USE: ids_in_use_ff <= csr_write_data[CNT_W-1:0];
            default: begin
               id_offset_ff <= id_offset_ff;
            end
         endcase
      end
   end

   // Item registers and result payload.
   always_ff @(posedge clock) begin
      op_ff              <= op_in;
      word_ff            <= word_in;
      bit_ff             <= bit_in;
      rsp_result_id_ff   <= rsp_result_id_in;
      rsp_success_ff     <= rsp_success_in;
      rsp_answer_flag_ff <= rsp_answer_flag_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_id   = rsp_result_id_ff;
   assign rsp_success     = rsp_success_ff;
   assign rsp_answer_flag = rsp_answer_flag_ff;

endmodule

@@ sv/bia_ram.sv @@
module bia_ram
   import bia_pkg::*;
#(
   parameter int DATA_W = 64,
   parameter int DEPTH  = 64
)
(
   input  logic                                         clock,
   input  logic                                         we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [DATA_W-1:0]                            wdata,
   input  logic                                         re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [DATA_W-1:0]                            rdata
);

   logic [DATA_W-1:0] mem [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

@@ sv/bia_ffs.sv @@
module bia_ffs
   import bia_pkg::*;
#(
   parameter int WIDTH = 64
)
(
   input  logic [WIDTH-1:0]         vec,
   output logic                     found,
   output logic [$clog2(WIDTH)-1:0] index
);

   // Priority encoder: the lowest set bit wins.
   always_comb begin
      found = |vec;
      index = '0;
      for (int i = WIDTH - 1; i >= 0; i--) begin
         if (vec[i]) begin
            index = ($clog2(WIDTH))'(i);
         end
      end
   end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
   import bia_pkg::*;

   localparam int MAX_IDS     = 4096;
   localparam int ID_LO       = -32769;
   localparam int ID_HI       = 36863;
   localparam int CYCLE_LIMIT = 200000;

   // One item as the driver presents it.
   typedef struct {
      op_type               op;
      logic [ID_W-1:0]      id;
   } request_type;

   // One result as the block should answer it.
   typedef struct packed {
      logic [ID_W-1:0] result_id;
      logic            success;
      logic            answer_flag;
   } outcome_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [1:0]            req_op = OP_VALID;
   logic [ID_W-1:0]       req_id = '0;
   logic                  rsp_valid;
   logic [ID_W-1:0]       rsp_result_id;
   logic                  rsp_success;
   logic                  rsp_answer_flag;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_ID_OFFSET;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   // Shadow copies of the registers and the used marks.
   logic [OFF_W-1:0]      id_offset_copy = '0;
   logic [CNT_W-1:0]      id_count_copy = CNT_W'(MAX_IDS);
   bit                    used_mark [MAX_IDS];

   request_type           pending_reqs [$];
   outcome_type           outcomes_due [$];
   int                    fails = 0;
   int                    cycles = 0;
   int                    gap_left = 0;
   int                    steady_left = 0;

   bitmap_id_allocator #(
      .MAX_IDS   (MAX_IDS),
      .WORD_BITS (64)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_id          (req_id),
      .rsp_valid       (rsp_valid),
      .rsp_result_id   (rsp_result_id),
      .rsp_success     (rsp_success),
      .rsp_answer_flag (rsp_answer_flag),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   always #5 clock = ~clock;

   // Work out the answer to one item and update the shadow marks.
   function automatic outcome_type allocator_outcome(op_type op, logic [ID_W-1:0] id);
      outcome_type o;
      int       off;
      int       size;
      int       idx;
      int       found;
      logic     in_range;
      o = '0;
      off = int'($signed(id_offset_copy));
      size = (id_count_copy > MAX_IDS) ? MAX_IDS : int'(id_count_copy);
      idx = int'($signed(id)) - off;
      in_range = (idx >= 0) && (idx < size);
      case (op)
         OP_ALLOC: begin
            found = -1;
            for (int i = 0; i < size && found < 0; i++) begin
               if (!used_mark[i]) found = i;
            end
            if (found >= 0) begin
               used_mark[found] = 1'b1;
               o.result_id = ID_W'(found + off);
               o.success = 1'b1;
            end else begin
               o.result_id = ID_W'(off - 1);
            end
         end
         OP_RELEASE: begin
            if (in_range) begin
               used_mark[idx] = 1'b0;
               o.success = 1'b1;
            end
         end
         OP_USED: begin
            o.answer_flag = in_range && used_mark[idx];
         end
         default: begin
            o.answer_flag = in_range;
         end
      endcase
      return o;
   endfunction

   // Driver: presents queued items, holding each until the block takes it.
   always @(posedge clock) begin
      request_type nxt;
      if (reset) begin
         start <= 1'b0;
         gap_left = 0;
      end else if (!start || !busy) begin
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            nxt = pending_reqs.pop_front();
            req_op <= nxt.op;
            req_id <= nxt.id;
            start <= 1'b1;
            // A random idle gap, possibly none, before the next item; none during runs of back-to-back items.
            if (steady_left > 0) begin
               steady_left--;
               gap_left = 0;
            end else begin
               gap_left = $urandom_range(0, 5);
               if ($urandom_range(0, 40) == 0) steady_left = $urandom_range(10, 40);
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: checks each result, then records the item taken at this edge.
   always @(posedge clock) begin
      outcome_type want;
      if (!reset) begin
         if (rsp_valid !== 1'b0) begin
            if (outcomes_due.size() == 0) begin
               $error("result with no item waiting: result_id %0d", $signed(rsp_result_id));
               fails++;
            end else begin
               want = outcomes_due.pop_front();
               if (rsp_result_id !== want.result_id) begin
                  $error("result_id: expected %0d, got %0d",
                         $signed(want.result_id), $signed(rsp_result_id));
                  fails++;
               end
               if (rsp_success !== want.success) begin
                  $error("success: expected %0b, got %0b", want.success, rsp_success);
                  fails++;
               end
               if (rsp_answer_flag !== want.answer_flag) begin
                  $error("answer_flag: expected %0b, got %0b",
                         want.answer_flag, rsp_answer_flag);
                  fails++;
               end
            end
         end
         if (start && !busy) begin
            outcomes_due.push_back(allocator_outcome(op_type'(req_op), req_id));
         end
      end
   end

   // Cycle limit.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic queue_req(op_type op, int id);
      request_type r;
      r.op = op;
      r.id = ID_W'(id);
      pending_reqs.push_back(r);
   endtask

   // Register writes are only issued while the block is idle.
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      if (idx == CSR_ID_OFFSET) id_offset_copy = data;
      else id_count_copy = data[CNT_W-1:0];
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Wait until every queued item has been taken and answered.
   task automatic drain();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || start || outcomes_due.size() != 0);
   endtask

   // Random items, mostly on identifiers in and around the managed window.
   task automatic random_phase(int n);
      int     cnt_eff;
      int     off;
      int     id;
      int     r;
      op_type op;
      cnt_eff = (id_count_copy > MAX_IDS) ? MAX_IDS : int'(id_count_copy);
      off = int'($signed(id_offset_copy));
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(0, 19);
         if (r < 8) op = OP_ALLOC;
         else if (r < 13) op = OP_RELEASE;
         else if (r < 17) op = OP_USED;
         else op = OP_VALID;
         r = $urandom_range(0, 19);
         if (r == 0) begin
            id = int'($urandom_range(0, ID_HI - ID_LO)) + ID_LO;
         end else if (r < 10 && cnt_eff > 0) begin
            // Low indexes are where allocations land, so releases hit real marks.
            id = off + int'($urandom_range(0, (cnt_eff < 96 ? cnt_eff : 96) - 1));
         end else begin
            id = off - 3 + int'($urandom_range(0, cnt_eff + 6));
         end
         if (id < ID_LO) id = ID_LO;
         if (id > ID_HI) id = ID_HI;
         queue_req(op, id);
      end
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] off_val;
      logic [CSR_DATA_W-1:0] cnt_val;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Registers at reset: window edges, extreme identifiers, and a freed
      // identifier being handed out again before higher ones.
      queue_req(OP_VALID, 0);
      queue_req(OP_VALID, 4095);
      queue_req(OP_VALID, 4096);
      queue_req(OP_VALID, -1);
      queue_req(OP_USED, ID_LO);
      queue_req(OP_RELEASE, ID_HI);
      queue_req(OP_USED, 0);
      queue_req(OP_ALLOC, 0);
      queue_req(OP_ALLOC, 0);
      queue_req(OP_USED, 0);
      queue_req(OP_RELEASE, 0);
      queue_req(OP_RELEASE, 0);
      queue_req(OP_USED, 0);
      queue_req(OP_ALLOC, ID_LO);
      drain();

      // A count of zero makes nothing valid and every allocate fail.
      write_csr(CSR_IDS_IN_USE, 16'd0);
      queue_req(OP_ALLOC, 0);
      queue_req(OP_VALID, 0);
      drain();

      // A count above capacity acts as the full capacity.
      write_csr(CSR_IDS_IN_USE, 16'd8191);
      queue_req(OP_VALID, 4095);
      queue_req(OP_VALID, 4096);
      drain();

      // Lowest offset with two ids, both already marked: the allocate fails.
      write_csr(CSR_ID_OFFSET, 16'h8000);
      write_csr(CSR_IDS_IN_USE, 16'd2);
      queue_req(OP_ALLOC, 0);
      queue_req(OP_VALID, -32768);
      drain();

      // Lowering the count hides a mark; raising it again shows it.
      write_csr(CSR_IDS_IN_USE, 16'd1);
      queue_req(OP_USED, -32767);
      drain();
      write_csr(CSR_ID_OFFSET, 16'h7FFF);
      write_csr(CSR_IDS_IN_USE, 16'd4096);
      queue_req(OP_USED, 32768);
      queue_req(OP_ALLOC, 0);
      queue_req(OP_VALID, 36862);
      queue_req(OP_VALID, ID_HI);
      drain();

      // Random phases, each under a fresh register setting.
      for (int p = 0; p < 19; p++) begin
         case ($urandom_range(0, 3))
            0: off_val = 16'h8000;
            1: off_val = 16'h7FFF;
            2: off_val = 16'h0000;
            default: off_val = CSR_DATA_W'($urandom_range(0, 16'hFFFF));
         endcase
         case ($urandom_range(0, 7))
            0: cnt_val = 16'd0;
            1: cnt_val = 16'd1;
            2: cnt_val = 16'd64;
            3: cnt_val = 16'd65;
            4: cnt_val = 16'd4096;
            5: cnt_val = CSR_DATA_W'($urandom_range(4097, 8191));
            default: cnt_val = CSR_DATA_W'($urandom_range(2, 200));
         endcase
         write_csr(CSR_ID_OFFSET, off_val);
         write_csr(CSR_IDS_IN_USE, cnt_val);
         random_phase(100);
         drain();
      end

      repeat (4) @(posedge clock);
      if (fails == 0 && outcomes_due.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

@@ bitmap_id_allocator.f @@
sv/bia_pkg.sv
sv/bia_ram.sv
sv/bia_ffs.sv
sv/bitmap_id_allocator.sv
test/testbench.sv
